FILE: rtl/core/tdsm_pkg.sv
`default_nettype none

package tdsm_pkg;

    // Item kinds carried by the req_type field.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [9:0] SATURATE_MAX     = 10'd999;
    localparam logic [7:0] POINT_CLEAR_MASK = 8'h7F;
    localparam logic [7:0] BLANK_SEGMENTS   = 8'hFF;

    // Active-low digit enables: bit 2 hundreds, bit 1 tens, bit 0 ones.
    localparam logic [2:0] EN_HUNDREDS = 3'b011;
    localparam logic [2:0] EN_TENS     = 3'b101;
    localparam logic [2:0] EN_ONES     = 3'b110;
    localparam logic [2:0] EN_NONE     = 3'b111;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       req_type;
        logic [9:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] segments;
        logic [2:0] digit_enables;
    } t_out_item;

    // Classified command: the hundreds digit and the remainder below 100.
    typedef struct packed {
        logic       req_type;
        logic [3:0] hundreds;
        logic [6:0] remainder;
    } t_cmd;

    // Segment patterns for the digit codes 0 to 15.
    function automatic logic [7:0] f_segment(input logic [3:0] digit);
        logic [7:0] pattern;
        unique case (digit)
            4'd0:    pattern = 8'hDF;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'hBB;
            4'd3:    pattern = 8'hAF;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h6F;
            4'd10:   pattern = 8'h77;
            4'd11:   pattern = 8'h7C;
            4'd12:   pattern = 8'h39;
            4'd13:   pattern = 8'h5E;
            4'd14:   pattern = 8'h79;
            default: pattern = 8'h71;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tdsm_front.sv
`default_nettype none

module tdsm_front import tdsm_pkg::*; (
    input  var t_in_item i_item,
    output t_cmd         o_cmd
);

    logic [9:0]  sat_value;
    logic [15:0] hund_product;
    logic [3:0]  hundreds;
    logic [9:0]  hund_scaled;
    logic [9:0]  remainder;

    // Division by 100 is a multiply by 41 and a shift of 12, exact below 1000.
    always_comb begin
        sat_value    = (i_item.value > SATURATE_MAX) ? SATURATE_MAX : i_item.value;
        hund_product = 16'(sat_value) * 16'd41;
        hundreds     = hund_product[15:12];
        hund_scaled  = 10'(hundreds) * 10'd100;
        remainder    = sat_value - hund_scaled;
    end

    assign o_cmd.req_type  = i_item.req_type;
    assign o_cmd.hundreds  = hundreds;
    assign o_cmd.remainder = remainder[6:0];

endmodule

`default_nettype wire

FILE: rtl/core/tdsm_queue.sv
`default_nettype none

module tdsm_queue import tdsm_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  var t_cmd i_data,
    output logic o_full,
    input  wire  i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(QUEUE_DEPTH - 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == DepthCnt);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != DepthCnt))
        else $error("queue written while full");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a lone write");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tdsm_back.sv
`default_nettype none

module tdsm_back import tdsm_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_cmd_valid,
    input  var t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [1:0] PH_HUNDREDS = 2'd0;
    localparam logic [1:0] PH_TENS     = 2'd1;
    localparam logic [1:0] PH_ONES     = 2'd2;

    localparam logic [1:0] DP_ONES     = 2'd0;
    localparam logic [1:0] DP_TENS     = 2'd1;
    localparam logic [1:0] DP_HUNDREDS = 2'd2;

    logic [7:0]  r_hund_pat, n_hund_pat;
    logic [7:0]  r_tens_pat, n_tens_pat;
    logic [7:0]  r_ones_pat, n_ones_pat;
    logic [1:0]  r_phase, n_phase;
    logic [1:0]  r_point, n_point;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic        out_free;
    logic        do_load;
    logic        do_tick;
    logic [13:0] tens_product;
    logic [3:0]  tens;
    logic [6:0]  tens_scaled;
    logic [6:0]  ones_wide;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_cmd_pop = i_cmd_valid && ((i_cmd.req_type == REQ_LOAD) || out_free);
    assign do_load   = o_cmd_pop && (i_cmd.req_type == REQ_LOAD);
    assign do_tick   = o_cmd_pop && (i_cmd.req_type == REQ_TICK);

    // Division by 10 of a value below 100: multiply by 103, shift by 10.
    always_comb begin
        tens_product = 14'(i_cmd.remainder) * 14'd103;
        tens         = tens_product[13:10];
        tens_scaled  = 7'(tens) * 7'd10;
        ones_wide    = i_cmd.remainder - tens_scaled;
    end

    always_comb begin
        n_hund_pat = r_hund_pat;
        n_tens_pat = r_tens_pat;
        n_ones_pat = r_ones_pat;
        n_point    = r_point;
        if (do_load) begin
            n_hund_pat = f_segment(i_cmd.hundreds);
            n_tens_pat = f_segment(tens);
            n_ones_pat = f_segment(ones_wide[3:0]);
            unique case (r_point)
                DP_ONES: begin
                    n_ones_pat = n_ones_pat & POINT_CLEAR_MASK;
                    n_point    = DP_TENS;
                end
                DP_TENS: begin
                    n_tens_pat = n_tens_pat & POINT_CLEAR_MASK;
                    n_point    = DP_HUNDREDS;
                end
                DP_HUNDREDS: begin
                    n_hund_pat = n_hund_pat & POINT_CLEAR_MASK;
                    n_point    = DP_ONES;
                end
                default: begin
                    n_point    = DP_ONES;
                end
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;
        if (do_tick) begin
            n_out_valid = 1'b1;
            unique case (r_phase)
                PH_HUNDREDS: begin
                    n_out_item.segments      = r_hund_pat;
                    n_out_item.digit_enables = EN_HUNDREDS;
                    n_phase                  = PH_TENS;
                end
                PH_TENS: begin
                    n_out_item.segments      = r_tens_pat;
                    n_out_item.digit_enables = EN_TENS;
                    n_phase                  = PH_ONES;
                end
                PH_ONES: begin
                    n_out_item.segments      = r_ones_pat;
                    n_out_item.digit_enables = EN_ONES;
                    n_phase                  = PH_HUNDREDS;
                end
                default: begin
                    n_out_item.segments      = BLANK_SEGMENTS;
                    n_out_item.digit_enables = EN_NONE;
                    n_phase                  = PH_HUNDREDS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hund_pat  <= '0;
            r_tens_pat  <= '0;
            r_ones_pat  <= '0;
            r_phase     <= PH_HUNDREDS;
            r_point     <= DP_ONES;
            r_out_valid <= 1'b0;
        end else begin
            r_hund_pat  <= n_hund_pat;
            r_tens_pat  <= n_tens_pat;
            r_ones_pat  <= n_ones_pat;
            r_phase     <= n_phase;
            r_point     <= n_point;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_tick_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick |=> o_out_valid)
        else $error("tick popped without a result");
    a_phase_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick |=> (r_phase != $past(r_phase)))
        else $error("scan phase did not move on a tick");
    a_load_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !do_tick) |=> $stable(r_phase))
        else $error("scan phase moved without a tick");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/three_digit_seven_segment_mux.sv
// A tick item passes through the command queue and then the output register.
// Throughput: one item per cycle, loads and ticks alike, unless an output stall
// holds a tick in the queue; set by the pop of the two-entry command queue and
// the single output register.
// A load item yields no result; it updates the stored digit patterns.
// Reset (i_rst_n low at a rising edge) clears the patterns, the scan phase
// (hundreds next), the decimal-point position (ones next) and the queue.
`default_nettype none

module three_digit_seven_segment_mux import tdsm_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  var t_in_item i_in_item,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_item
);

    // The front classifies every item as it arrives: the value is saturated
    // to 999 and split into the hundreds digit and a remainder below 100.
    // The command then waits in a short queue, so the input side stalls only
    // when the queue is full, never directly because the output is stalled.
    // The back finishes the split into tens and ones, looks up the segment
    // patterns and rotates the decimal point on loads, and drives one digit
    // of the hundreds, tens, ones scan on ticks through an output register.

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic in_accept;

    assign o_in_stall = queue_full;
    assign in_accept  = i_in_valid && !queue_full;

    tdsm_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    tdsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    tdsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
